// ----- rtl/core/dla_pkg.sv -----
// Shared types, constants and helper functions for the digital lock-in amplifier.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package dla_pkg;

  localparam int HARMONIC_COUNT = 5;
  localparam int CORDIC_STEPS   = 18;
  localparam int ROOT_STEPS     = 32;

  // Configuration register indexes
  localparam logic [2:0] CFG_STEP_COS   = 3'd0;
  localparam logic [2:0] CFG_STEP_SIN   = 3'd1;
  localparam logic [2:0] CFG_HARMONIC   = 3'd2;
  localparam logic [2:0] CFG_GAIN       = 3'd3;
  localparam logic [2:0] CFG_COEF       = 3'd4;
  localparam logic [2:0] CFG_TWO_POLE   = 3'd5;
  localparam logic [2:0] CFG_FRAME_COS  = 3'd6;
  localparam logic [2:0] CFG_FRAME_SIN  = 3'd7;

  localparam logic signed [65:0] Q30_ONE   = 66'sd1073741824;
  localparam logic signed [65:0] Q30_THREE = 66'sd3221225472;

  typedef struct packed {
    logic [30:0] step_cos;
    logic [30:0] step_sin;
    logic [2:0]  harmonic;
    logic [16:0] gain;
    logic [39:0] coef;
    logic        two_pole;
    logic [30:0] frame_cos;
    logic [30:0] frame_sin;
  } cfg_t;

  // Request to the shared rounding multiplier
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
    logic [5:0]  sh;
    logic [6:0]  bits;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [30:0] sat31(input logic signed [31:0] v);
    logic [30:0] r;
    if (v > 32'sd1073741823) r = 31'h3FFFFFFF;
    else if (v < -32'sd1073741824) r = 31'h40000000;
    else r = v[30:0];
    return r;
  endfunction

  // Arctangent of 2^-k in units of pi/2^24
  function automatic logic signed [26:0] atan_step(input logic [4:0] k);
    logic signed [26:0] r;
    case (k)
      5'd0:  r = 27'sd4194304;
      5'd1:  r = 27'sd2476042;
      5'd2:  r = 27'sd1308273;
      5'd3:  r = 27'sd664100;
      5'd4:  r = 27'sd333339;
      5'd5:  r = 27'sd166832;
      5'd6:  r = 27'sd83436;
      5'd7:  r = 27'sd41721;
      5'd8:  r = 27'sd20861;
      5'd9:  r = 27'sd10430;
      5'd10: r = 27'sd5215;
      5'd11: r = 27'sd2608;
      5'd12: r = 27'sd1304;
      5'd13: r = 27'sd652;
      5'd14: r = 27'sd326;
      5'd15: r = 27'sd163;
      5'd16: r = 27'sd81;
      5'd17: r = 27'sd41;
      default: r = 27'sd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/dla_front.sv -----
// Input side: two-entry sample queue between the input channel and the back end.
// Depends on dla_pkg.
`timescale 1ns / 1ps

module dla_front import dla_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   q_valid,
  output logic [SAMPLE_BITS-1:0] q_sample,
  input  logic                   q_pop
);

  logic [SAMPLE_BITS-1:0] mem_r [2];
  logic                   wr_ptr_r;
  logic                   rd_ptr_r;
  logic [1:0]             count_r;
  logic                   push;
  logic                   pop;

  assign in_stall = (count_r == 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_sample = mem_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= in_sample;
        wr_ptr_r        <= !wr_ptr_r;
      end
      if (pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- rtl/core/dla_mul.sv -----
// Shared multiply unit: exact signed product from 32x32 partial products,
// rounded half away from zero after a right shift, then saturated. Depends on dla_pkg.
`timescale 1ns / 1ps

module dla_mul import dla_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  typedef enum logic [1:0] {M_IDLE, M_PROD, M_RND, M_SAT} mstate_t;

  mstate_t      state_r;
  logic [63:0]  ua_r, ub_r;
  logic         neg_r;
  logic [5:0]   sh_r;
  logic [6:0]   bits_r;
  logic [2:0]   cnt_r;
  logic [63:0]  pp_r;
  logic [1:0]   off_r;
  logic [127:0] acc_r;
  logic         done_r;
  logic [63:0]  p_r;

  logic [63:0]  a_mag, b_mag;
  logic [31:0]  ua_h, ub_h;
  logic [63:0]  prod;
  logic [127:0] pp_shift;
  logic [127:0] half;
  logic [63:0]  lim;
  logic [63:0]  lim_m1;
  logic         big;
  logic [63:0]  mag;

  assign a_mag = req.a[63] ? (~req.a + 64'd1) : req.a;
  assign b_mag = req.b[63] ? (~req.b + 64'd1) : req.b;
  assign ua_h  = cnt_r[0] ? ua_r[63:32] : ua_r[31:0];
  assign ub_h  = cnt_r[1] ? ub_r[63:32] : ub_r[31:0];
  assign prod  = ua_h * ub_h;
  assign half  = (sh_r == 6'd0) ? 128'd0 : (128'd1 << (sh_r - 6'd1));
  assign lim    = 64'd1 << 6'(bits_r - 7'd1);
  assign lim_m1 = lim - 64'd1;
  assign big    = |acc_r[127:64];

  always_comb begin
    case (off_r)
      2'd0:    pp_shift = {64'd0, pp_r};
      2'd1:    pp_shift = {32'd0, pp_r, 32'd0};
      2'd2:    pp_shift = {pp_r, 64'd0};
      default: pp_shift = 128'd0;
    endcase
    if (neg_r) mag = (big || acc_r[63:0] > lim) ? lim : acc_r[63:0];
    else       mag = (big || acc_r[63:0] > lim_m1) ? lim_m1 : acc_r[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        M_IDLE: begin
          if (req.start) begin
            ua_r    <= a_mag;
            ub_r    <= b_mag;
            neg_r   <= req.a[63] ^ req.b[63];
            sh_r    <= req.sh;
            bits_r  <= req.bits;
            acc_r   <= 128'd0;
            cnt_r   <= 3'd0;
            state_r <= M_PROD;
          end
        end
        M_PROD: begin
          if (cnt_r != 3'd4) begin
            pp_r  <= prod;
            off_r <= {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
          end
          if (cnt_r != 3'd0) acc_r <= acc_r + pp_shift;
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd4) state_r <= M_RND;
        end
        M_RND: begin
          acc_r   <= (acc_r + half) >> sh_r;
          state_r <= M_SAT;
        end
        M_SAT: begin
          p_r     <= neg_r ? (~mag + 64'd1) : mag;
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = p_r;

endmodule

// ----- rtl/core/dla_back.sv -----
// Back end: sequencer that runs one sample through harmonics, mixing, filters,
// frame rotation and oscillator advance on dla_mul, then root and CORDIC phase.
// Depends on dla_pkg and dla_mul.
`timescale 1ns / 1ps

module dla_back import dla_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int FILTER_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   q_valid,
  input  logic [SAMPLE_BITS-1:0] q_sample,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [31:0]            out_in_phase,
  output logic [31:0]            out_quadrature,
  output logic [30:0]            out_magnitude,
  output logic [15:0]            out_phase,
  output logic [30:0]            out_reference_cos,
  output logic [30:0]            out_second_harmonic_cos
);

  typedef enum logic [2:0] {B_IDLE, B_ISSUE, B_WAIT, B_ROOT, B_OUT} bstate_t;

  typedef enum logic [5:0] {
    U_C2, U_S2, U_C3A, U_C3B, U_S3A, U_S3B, U_C4, U_S4,
    U_C5A, U_C5B, U_S5A, U_S5B,
    U_MI1, U_MI2, U_MQ1, U_MQ2,
    U_I1A, U_I1B, U_I2A, U_I2B, U_Q1A, U_Q1B, U_Q2A, U_Q2B,
    U_TIA, U_TIB, U_TQA, U_TQB, U_OI, U_OQ, U_SQI, U_SQQ,
    U_AA, U_AB, U_BA, U_BB, U_NA, U_NB, U_RE, U_IM, U_C2O
  } uop_t;

  localparam logic signed [65:0] F_MAX = (66'sd1 <<< (FILTER_BITS - 1)) - 66'sd1;
  localparam logic signed [65:0] F_MIN = -F_MAX - 66'sd1;
  localparam logic [6:0] F_BITS = 7'(FILTER_BITS);

  function automatic logic signed [FILTER_BITS-1:0] sat_f(input logic signed [65:0] v);
    logic signed [FILTER_BITS-1:0] r;
    if (v > F_MAX) r = F_MAX[FILTER_BITS-1:0];
    else if (v < F_MIN) r = F_MIN[FILTER_BITS-1:0];
    else r = v[FILTER_BITS-1:0];
    return r;
  endfunction

  bstate_t state_r;
  uop_t    uop_r;

  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [31:0] osc_re_r, osc_im_r;
  logic signed [31:0] c2_r, s2_r, c3_r, s3_r, c4_r, s4_r, c5_r, s5_r;
  logic signed [63:0] tmp_r;
  logic signed [FILTER_BITS-1:0] mi_r, mq_r, i1_r, i2_r, q1_r, q2_r;
  logic signed [62:0] ti_r, tq_r;
  logic signed [31:0] oi_r, oq_r;
  logic [63:0]        sq_r;
  logic signed [31:0] a_r, b_r;
  logic signed [35:0] corr_r;
  logic signed [31:0] c2o_r;

  logic [63:0]        n_r, res_r;
  logic [4:0]         cnt_r;
  logic signed [50:0] cx_r, cy_r;
  logic signed [26:0] ang_r;
  logic               zero_r;

  logic               out_valid_r;
  logic [31:0]        o_ip_r, o_qd_r;
  logic [30:0]        o_mag_r;
  logic [15:0]        o_ph_r;
  logic [30:0]        o_rc_r, o_sh_r;

  mul_req_t req;
  mul_rsp_t rsp;

  dla_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  logic [2:0]         hsel;
  logic signed [31:0] cos_h, sin_h;
  logic signed [FILTER_BITS-1:0] fi, fq;
  logic [40:0]        k2;
  logic signed [65:0] wt, wp, s_add, s_sub, s_dbl, s_dbl1, s_corr;
  logic [63:0]        op_a, op_b;
  logic [5:0]         op_sh;
  logic [6:0]         op_bits;

  logic [63:0]        bitv, trial;
  logic signed [50:0] dx, dy;
  logic signed [31:0] ox, oy;
  logic [26:0]        ang_mag;
  logic [17:0]        ang_rnd;
  logic [16:0]        neg_m;
  logic [15:0]        ph;

  assign hsel  = (cfg.harmonic > 3'(HARMONIC_COUNT - 1)) ? 3'(HARMONIC_COUNT - 1) : cfg.harmonic;
  assign fi    = cfg.two_pole ? i2_r : i1_r;
  assign fq    = cfg.two_pole ? q2_r : q1_r;
  assign k2    = 41'h100_0000_0000 - {1'b0, cfg.coef};
  assign wt    = {{2{tmp_r[63]}}, tmp_r};
  assign wp    = {{2{rsp.p[63]}}, rsp.p};
  assign s_add  = wt + wp;
  assign s_sub  = wt - wp;
  assign s_dbl  = wp + wp;
  assign s_dbl1 = s_dbl - Q30_ONE;
  assign s_corr = Q30_THREE - wt - wp;

  always_comb begin
    case (hsel)
      3'd1:    begin cos_h = c2_r; sin_h = s2_r; end
      3'd2:    begin cos_h = c3_r; sin_h = s3_r; end
      3'd3:    begin cos_h = c4_r; sin_h = s4_r; end
      3'd4:    begin cos_h = c5_r; sin_h = s5_r; end
      default: begin cos_h = osc_re_r; sin_h = osc_im_r; end
    endcase
  end

  // Operand selection for the current step
  always_comb begin
    op_a    = 64'(osc_re_r);
    op_b    = 64'(osc_re_r);
    op_sh   = 6'd30;
    op_bits = 7'd64;
    case (uop_r)
      U_C2:  begin op_a = 64'(osc_re_r); op_b = 64'(osc_re_r); end
      U_S2:  begin op_a = 64'(osc_im_r); op_b = 64'(osc_re_r); end
      U_C3A: begin op_a = 64'(osc_re_r); op_b = 64'(c2_r); end
      U_C3B: begin op_a = 64'(osc_im_r); op_b = 64'(s2_r); end
      U_S3A: begin op_a = 64'(osc_im_r); op_b = 64'(c2_r); end
      U_S3B: begin op_a = 64'(osc_re_r); op_b = 64'(s2_r); end
      U_C4:  begin op_a = 64'(c2_r); op_b = 64'(c2_r); end
      U_S4:  begin op_a = 64'(s2_r); op_b = 64'(c2_r); end
      U_C5A: begin op_a = 64'(osc_re_r); op_b = 64'(c4_r); end
      U_C5B: begin op_a = 64'(osc_im_r); op_b = 64'(s4_r); end
      U_S5A: begin op_a = 64'(osc_im_r); op_b = 64'(c4_r); end
      U_S5B: begin op_a = 64'(osc_re_r); op_b = 64'(s4_r); end
      U_MI1: begin op_a = 64'(x_r); op_b = 64'(cos_h); op_sh = 6'd14; end
      U_MQ1: begin op_a = 64'(x_r); op_b = 64'(sin_h); op_sh = 6'd14; end
      U_MI2, U_MQ2: begin
        op_a = tmp_r; op_b = {46'd0, cfg.gain, 1'b0}; op_sh = 6'd0; op_bits = F_BITS;
      end
      U_I1A: begin op_a = 64'(i1_r); op_b = 64'(k2); op_sh = 6'd40; end
      U_I1B: begin op_a = 64'(mi_r); op_b = 64'(cfg.coef); op_sh = 6'd40; end
      U_I2A: begin op_a = 64'(i2_r); op_b = 64'(k2); op_sh = 6'd40; end
      U_I2B: begin op_a = 64'(i1_r); op_b = 64'(cfg.coef); op_sh = 6'd40; end
      U_Q1A: begin op_a = 64'(q1_r); op_b = 64'(k2); op_sh = 6'd40; end
      U_Q1B: begin op_a = 64'(mq_r); op_b = 64'(cfg.coef); op_sh = 6'd40; end
      U_Q2A: begin op_a = 64'(q2_r); op_b = 64'(k2); op_sh = 6'd40; end
      U_Q2B: begin op_a = 64'(q1_r); op_b = 64'(cfg.coef); op_sh = 6'd40; end
      U_TIA: begin
        op_a = 64'($signed(cfg.frame_cos)); op_b = 64'(fi); op_bits = 7'd62;
      end
      U_TIB: begin
        op_a = 64'($signed(cfg.frame_sin)); op_b = 64'(fq); op_bits = 7'd62;
      end
      U_TQA: begin
        op_a = 64'($signed(cfg.frame_cos)); op_b = 64'(fq); op_bits = 7'd62;
      end
      U_TQB: begin
        op_a = 64'($signed(cfg.frame_sin)); op_b = 64'(fi); op_bits = 7'd62;
      end
      U_OI:  begin op_a = 64'(ti_r); op_b = 64'd1; op_sh = 6'd16; op_bits = 7'd32; end
      U_OQ:  begin op_a = 64'(tq_r); op_b = 64'd1; op_sh = 6'd16; op_bits = 7'd32; end
      U_SQI: begin op_a = 64'(oi_r); op_b = 64'(oi_r); op_sh = 6'd0; end
      U_SQQ: begin op_a = 64'(oq_r); op_b = 64'(oq_r); op_sh = 6'd0; end
      U_AA:  begin op_a = 64'($signed(cfg.step_cos)); op_b = 64'(osc_re_r); end
      U_AB:  begin op_a = 64'($signed(cfg.step_sin)); op_b = 64'(osc_im_r); end
      U_BA:  begin op_a = 64'($signed(cfg.step_cos)); op_b = 64'(osc_im_r); end
      U_BB:  begin op_a = 64'($signed(cfg.step_sin)); op_b = 64'(osc_re_r); end
      U_NA:  begin op_a = 64'(a_r); op_b = 64'(a_r); end
      U_NB:  begin op_a = 64'(b_r); op_b = 64'(b_r); end
      U_RE:  begin op_a = 64'(a_r); op_b = 64'(corr_r); op_bits = 7'd32; end
      U_IM:  begin op_a = 64'(b_r); op_b = 64'(corr_r); op_bits = 7'd32; end
      U_C2O: begin op_a = 64'(osc_re_r); op_b = 64'(osc_re_r); end
      default: begin op_a = 64'd0; op_b = 64'd0; end
    endcase
  end

  assign req.start = (state_r == B_ISSUE);
  assign req.a     = op_a;
  assign req.b     = op_b;
  assign req.sh    = op_sh;
  assign req.bits  = op_bits;

  // Root and phase datapaths
  assign bitv  = 64'd1 << (6'd62 - {cnt_r, 1'b0});
  assign trial = res_r + bitv;
  assign dx    = cx_r >>> cnt_r;
  assign dy    = cy_r >>> cnt_r;
  assign ox    = oi_r;
  assign oy    = oq_r;

  always_comb begin
    ang_mag = ang_r[26] ? (~ang_r + 27'd1) : ang_r;
    ang_rnd = 18'((ang_mag + 27'd256) >> 9);
    neg_m   = (ang_rnd > 18'd32768) ? 17'd32768 : ang_rnd[16:0];
    if (zero_r)        ph = 16'd0;
    else if (ang_r[26]) ph = 16'(~neg_m + 17'd1);
    else               ph = (ang_rnd > 18'd32767) ? 16'h7FFF : ang_rnd[15:0];
  end

  assign q_pop = (state_r == B_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      uop_r       <= U_C2;
      out_valid_r <= 1'b0;
      osc_re_r    <= 32'sd1073741824;
      osc_im_r    <= 32'sd0;
      i1_r        <= '0;
      i2_r        <= '0;
      q1_r        <= '0;
      q2_r        <= '0;
    end else begin
      // Drop valid once taken, unless a new result is loaded this cycle
      if (out_valid_r && !out_stall && state_r != B_OUT) out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            x_r     <= q_sample;
            uop_r   <= U_C2;
            state_r <= B_ISSUE;
          end
        end
        B_ISSUE: state_r <= B_WAIT;
        B_WAIT: begin
          if (rsp.done) begin
            state_r <= B_ISSUE;
            uop_r   <= uop_t'(uop_r + 6'd1);
            case (uop_r)
              U_C2:  c2_r <= sat32(s_dbl1);
              U_S2:  s2_r <= sat32(s_dbl);
              U_C3B: c3_r <= sat32(s_sub);
              U_S3B: s3_r <= sat32(s_add);
              U_C4:  c4_r <= sat32(s_dbl1);
              U_S4:  s4_r <= sat32(s_dbl);
              U_C5B: c5_r <= sat32(s_sub);
              U_S5B: s5_r <= sat32(s_add);
              U_MI2: mi_r <= rsp.p[FILTER_BITS-1:0];
              U_MQ2: mq_r <= rsp.p[FILTER_BITS-1:0];
              U_I1B: i1_r <= sat_f(s_add);
              U_I2B: i2_r <= sat_f(s_add);
              U_Q1B: q1_r <= sat_f(s_add);
              U_Q2B: q2_r <= sat_f(s_add);
              U_TIB: ti_r <= s_add[62:0];
              U_TQB: tq_r <= s_sub[62:0];
              U_OI:  oi_r <= rsp.p[31:0];
              U_OQ:  oq_r <= rsp.p[31:0];
              U_SQQ: sq_r <= s_add[63:0];
              U_AB:  a_r <= sat32(s_add);
              U_BB:  b_r <= sat32(s_sub);
              U_NB:  corr_r <= s_corr[36:1];
              U_RE:  osc_re_r <= rsp.p[31:0];
              U_IM:  osc_im_r <= rsp.p[31:0];
              U_C2O: begin
                c2o_r   <= sat32(s_dbl1);
                // Set up the root and the phase rotation
                n_r     <= sq_r;
                res_r   <= 64'd0;
                cnt_r   <= 5'd0;
                zero_r  <= (oi_r == 32'sd0) && (oq_r == 32'sd0);
                state_r <= B_ROOT;
                if (!ox[31]) begin
                  cx_r  <= {{3{ox[31]}}, ox, 16'd0};
                  cy_r  <= {{3{oy[31]}}, oy, 16'd0};
                  ang_r <= 27'sd0;
                end else if (!oy[31]) begin
                  cx_r  <= {{3{oy[31]}}, oy, 16'd0};
                  cy_r  <= -{{3{ox[31]}}, ox, 16'd0};
                  ang_r <= 27'sd8388608;
                end else begin
                  cx_r  <= -{{3{oy[31]}}, oy, 16'd0};
                  cy_r  <= {{3{ox[31]}}, ox, 16'd0};
                  ang_r <= -27'sd8388608;
                end
              end
              default: tmp_r <= rsp.p;
            endcase
          end
        end
        B_ROOT: begin
          if (n_r >= trial) begin
            n_r   <= n_r - trial;
            res_r <= (res_r >> 1) + bitv;
          end else begin
            res_r <= res_r >> 1;
          end
          if (cnt_r < 5'(CORDIC_STEPS)) begin
            if (!cy_r[50]) begin
              cx_r  <= cx_r + dy;
              cy_r  <= cy_r - dx;
              ang_r <= ang_r + atan_step(cnt_r);
            end else begin
              cx_r  <= cx_r - dy;
              cy_r  <= cy_r + dx;
              ang_r <= ang_r - atan_step(cnt_r);
            end
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(ROOT_STEPS - 1)) state_r <= B_OUT;
        end
        B_OUT: begin
          if (!out_valid_r || !out_stall) begin
            o_ip_r      <= oi_r;
            o_qd_r      <= oq_r;
            o_mag_r     <= (res_r > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : res_r[30:0];
            o_ph_r      <= ph;
            o_rc_r      <= sat31(osc_re_r);
            o_sh_r      <= sat31(c2o_r);
            out_valid_r <= 1'b1;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid               = out_valid_r;
  assign out_in_phase            = o_ip_r;
  assign out_quadrature          = o_qd_r;
  assign out_magnitude           = o_mag_r;
  assign out_phase               = o_ph_r;
  assign out_reference_cos       = o_rc_r;
  assign out_second_harmonic_cos = o_sh_r;

endmodule

// ----- rtl/core/digital_lockin_amplifier.sv -----
// Top level of the digital lock-in amplifier: configuration registers, input queue
// and processing back end. Depends on dla_pkg, dla_front, dla_back.
//
// Usage:
// - Input channel (in_valid / in_stall / in_sample): one signed ADC sample per
//   transaction. A two-entry queue takes samples while the back end is busy.
// - Result channel (out_valid / out_stall / out_*): one transaction per sample
//   with I, Q, magnitude, phase (fraction of pi, Q0.15), reference cosine and
//   second-harmonic cosine. A result register holds the transaction while the
//   receiver stalls; the back end then waits with its next result finished.
// - Configuration: cfg_we writes cfg_wdata into register cfg_index at once.
//   Write only while no sample is in work.
// - Processing: 41 products through one shared 32x32 multiplier, then the
//   square root with the 18-step phase CORDIC running alongside, plus entry
//   and exit. One sample is in work at a time; the next sample is taken only
//   once the last result has gone into the result register.
// - Reset (rst_n low, synchronous): registers return to defaults, oscillator
//   to phase zero, filters to zero, queue and result register empty.
`timescale 1ns / 1ps

module digital_lockin_amplifier import dla_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int FILTER_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [31:0]            out_in_phase,
  output logic [31:0]            out_quadrature,
  output logic [30:0]            out_magnitude,
  output logic [15:0]            out_phase,
  output logic [30:0]            out_reference_cos,
  output logic [30:0]            out_second_harmonic_cos,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [39:0]            cfg_wdata
);

  cfg_t                   cfg_r;
  logic                   q_valid;
  logic [SAMPLE_BITS-1:0] q_sample;
  logic                   q_pop;

  // Configuration registers; no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_cos  <= 31'h3FFF_FFFF;
      cfg_r.step_sin  <= 31'd0;
      cfg_r.harmonic  <= 3'd0;
      cfg_r.gain      <= 17'd1;
      cfg_r.coef      <= 40'd1;
      cfg_r.two_pole  <= 1'b1;
      cfg_r.frame_cos <= 31'h3FFF_FFFF;
      cfg_r.frame_sin <= 31'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_COS:  cfg_r.step_cos  <= cfg_wdata[30:0];
        CFG_STEP_SIN:  cfg_r.step_sin  <= cfg_wdata[30:0];
        CFG_HARMONIC:  cfg_r.harmonic  <= cfg_wdata[2:0];
        CFG_GAIN:      cfg_r.gain      <= cfg_wdata[16:0];
        CFG_COEF:      cfg_r.coef      <= cfg_wdata[39:0];
        CFG_TWO_POLE:  cfg_r.two_pole  <= cfg_wdata[0];
        CFG_FRAME_COS: cfg_r.frame_cos <= cfg_wdata[30:0];
        CFG_FRAME_SIN: cfg_r.frame_sin <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // Buffer incoming samples so the source can run ahead of the back end
  dla_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .q_valid   (q_valid),
    .q_sample  (q_sample),
    .q_pop     (q_pop)
  );

  // Mix, filter, rotate, advance the oscillator and hold the result
  dla_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FILTER_BITS (FILTER_BITS)
  ) u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg                     (cfg_r),
    .q_valid                 (q_valid),
    .q_sample                (q_sample),
    .q_pop                   (q_pop),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_in_phase            (out_in_phase),
    .out_quadrature          (out_quadrature),
    .out_magnitude           (out_magnitude),
    .out_phase               (out_phase),
    .out_reference_cos       (out_reference_cos),
    .out_second_harmonic_cos (out_second_harmonic_cos)
  );

endmodule

// ----- tb/sv/lockin_checker.sv -----
// Result checker for the digital lock-in amplifier: watches the three ports,
// predicts each result from its own model of oscillator, filters and CORDIC.
// Depends on dla_pkg for the register indexes and the harmonic count.
`timescale 1ns / 1ps

module lockin_checker import dla_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [23:0] in_sample,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_in_phase,
  input  logic [31:0] out_quadrature,
  input  logic [30:0] out_magnitude,
  input  logic [15:0] out_phase,
  input  logic [30:0] out_reference_cos,
  input  logic [30:0] out_second_harmonic_cos,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [39:0] cfg_wdata,
  output int          pending,
  output int          mismatches
);

  localparam longint ONE_Q30 = 64'sd1073741824;

  typedef struct {
    logic [31:0] in_phase;
    logic [31:0] quadrature;
    logic [30:0] magnitude;
    logic [15:0] phase;
    logic [30:0] reference_cos;
    logic [30:0] second_harmonic_cos;
  } lockin_result_t;

  lockin_result_t expected_results[$];

  longint rot_step_cos, rot_step_sin, rot_frame_cos, rot_frame_sin;
  longint harm_sel, gain, coef, two_pole;
  longint osc_re, osc_im, i_one, i_two, q_one, q_two;
  int     err_count;

  assign mismatches = err_count;

  function automatic logic signed [127:0] wide(longint v);
    return 128'(v);
  endfunction

  // Exact product, shift with rounding half away from zero, saturate to bits
  function automatic longint mul_round(longint a, longint b, int sh, int bits);
    logic signed [127:0] wa, wb;
    logic [127:0] ua, ub, p, lim, mag;
    logic neg;
    wa = 128'(a);
    wb = 128'(b);
    neg = (a < 0) != (b < 0);
    ua = wa < 0 ? -wa : wa;
    ub = wb < 0 ? -wb : wb;
    p = ua * ub;
    if (sh > 0) p = (p + (128'd1 << (sh - 1))) >> sh;
    lim = 128'd1 << (bits - 1);
    if (neg) begin
      mag = p > lim ? lim : p;
      mag = -mag;
    end else begin
      mag = p > lim - 1 ? lim - 1 : p;
    end
    return mag[63:0];
  endfunction

  function automatic longint clamp(logic signed [127:0] v, int bits);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    else if (v < lo) v = lo;
    return v[63:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint angle_of(longint i, longint q);
    longint x, y, ang, t;
    longint atan_pi[18] = '{4194304, 2476042, 1308273, 664100, 333339, 166832, 83436,
                            41721, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41};
    if (i == 0 && q == 0) return 0;
    x = i * 65536;
    y = q * 65536;
    ang = 0;
    // fold the left half plane onto the right one
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; ang = 8388608;
      end else begin
        t = x; x = -y; y = t; ang = -8388608;
      end
    end
    for (int k = 0; k < 18; k++) begin
      t = x;
      if (y >= 0) begin
        x = x + (y >>> k); y = y - (t >>> k); ang = ang + atan_pi[k];
      end else begin
        x = x - (y >>> k); y = y + (t >>> k); ang = ang - atan_pi[k];
      end
    end
    return mul_round(ang, 1, 9, 16);
  endfunction

  function automatic longint rc_update(longint st, longint x);
    return clamp(wide(mul_round(st, (64'sd1 <<< 40) - coef, 40, 64))
                 + wide(mul_round(x, coef, 40, 64)), 64);
  endfunction

  task automatic predict_lockin(input logic [23:0] raw, output lockin_result_t r);
    longint hc[5], hs[5];
    longint x, h, mi, mq, fi, fq, ti, tq, oi, oq, a, b, corr, c2;
    logic [63:0] ui, uq, mag;
    x = longint'($signed(raw));
    h = harm_sel > HARMONIC_COUNT - 1 ? HARMONIC_COUNT - 1 : harm_sel;
    hc[0] = osc_re;
    hs[0] = osc_im;
    hc[1] = clamp(2 * wide(mul_round(hc[0], hc[0], 30, 64)) - ONE_Q30, 32);
    hs[1] = clamp(2 * wide(mul_round(hs[0], hc[0], 30, 64)), 32);
    hc[2] = clamp(wide(mul_round(hc[0], hc[1], 30, 64)) - mul_round(hs[0], hs[1], 30, 64), 32);
    hs[2] = clamp(wide(mul_round(hs[0], hc[1], 30, 64)) + mul_round(hc[0], hs[1], 30, 64), 32);
    hc[3] = clamp(2 * wide(mul_round(hc[1], hc[1], 30, 64)) - ONE_Q30, 32);
    hs[3] = clamp(2 * wide(mul_round(hs[1], hc[1], 30, 64)), 32);
    hc[4] = clamp(wide(mul_round(hc[0], hc[3], 30, 64)) - mul_round(hs[0], hs[3], 30, 64), 32);
    hs[4] = clamp(wide(mul_round(hs[0], hc[3], 30, 64)) + mul_round(hc[0], hs[3], 30, 64), 32);

    mi = mul_round(mul_round(x, hc[h], 14, 64), 2 * gain, 0, 64);
    mq = mul_round(mul_round(x, hs[h], 14, 64), 2 * gain, 0, 64);
    i_one = rc_update(i_one, mi);
    i_two = rc_update(i_two, i_one);
    q_one = rc_update(q_one, mq);
    q_two = rc_update(q_two, q_one);
    fi = two_pole != 0 ? i_two : i_one;
    fq = two_pole != 0 ? q_two : q_one;

    ti = mul_round(rot_frame_cos, fi, 30, 62) + mul_round(rot_frame_sin, fq, 30, 62);
    tq = mul_round(rot_frame_cos, fq, 30, 62) - mul_round(rot_frame_sin, fi, 30, 62);
    oi = mul_round(ti, 1, 16, 32);
    oq = mul_round(tq, 1, 16, 32);
    ui = oi < 0 ? -oi : oi;
    uq = oq < 0 ? -oq : oq;
    mag = floor_sqrt(ui * ui + uq * uq);
    if (mag > 64'd2147483647) mag = 64'd2147483647;

    // advance the oscillator, then pull it back to unit modulus
    a = clamp(wide(mul_round(rot_step_cos, osc_re, 30, 64))
              + mul_round(rot_step_sin, osc_im, 30, 64), 32);
    b = clamp(wide(mul_round(rot_step_cos, osc_im, 30, 64))
              - mul_round(rot_step_sin, osc_re, 30, 64), 32);
    corr = (3 * ONE_Q30 - mul_round(a, a, 30, 64) - mul_round(b, b, 30, 64)) >>> 1;
    osc_re = mul_round(a, corr, 30, 32);
    osc_im = mul_round(b, corr, 30, 32);
    c2 = clamp(2 * wide(mul_round(osc_re, osc_re, 30, 64)) - ONE_Q30, 32);

    r.in_phase = oi[31:0];
    r.quadrature = oq[31:0];
    r.magnitude = mag[30:0];
    r.phase = 16'(angle_of(oi, oq));
    r.reference_cos = 31'(clamp(osc_re, 31));
    r.second_harmonic_cos = 31'(clamp(c2, 31));
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_count++;
    end
  endtask

  initial err_count = 0;

  always @(posedge clk) begin
    lockin_result_t r;
    if (!rst_n) begin
      rot_step_cos = 1073741823; rot_step_sin = 0;
      harm_sel = 0; gain = 1; coef = 1; two_pole = 1;
      rot_frame_cos = 1073741823; rot_frame_sin = 0;
      osc_re = ONE_Q30; osc_im = 0;
      i_one = 0; i_two = 0; q_one = 0; q_two = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP_COS:  rot_step_cos = longint'($signed(cfg_wdata[30:0]));
          CFG_STEP_SIN:  rot_step_sin = longint'($signed(cfg_wdata[30:0]));
          CFG_HARMONIC:  harm_sel = longint'(cfg_wdata[2:0]);
          CFG_GAIN:      gain = longint'(cfg_wdata[16:0]);
          CFG_COEF:      coef = longint'(cfg_wdata[39:0]);
          CFG_TWO_POLE:  two_pole = longint'(cfg_wdata[0]);
          CFG_FRAME_COS: rot_frame_cos = longint'($signed(cfg_wdata[30:0]));
          CFG_FRAME_SIN: rot_frame_sin = longint'($signed(cfg_wdata[30:0]));
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_lockin(in_sample, r);
        expected_results.push_back(r);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no sample waiting for it");
          err_count++;
        end else begin
          r = expected_results.pop_front();
          check_field("in_phase", r.in_phase, out_in_phase);
          check_field("quadrature", r.quadrature, out_quadrature);
          check_field("magnitude", r.magnitude, out_magnitude);
          check_field("phase", r.phase, out_phase);
          check_field("reference_cos", r.reference_cos, out_reference_cos);
          check_field("second_harmonic_cos", r.second_harmonic_cos, out_second_harmonic_cos);
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ----- tb/sv/tb_digital_lockin_amplifier.sv -----
// Testbench top for the digital lock-in amplifier: clock, reset, sample and
// register stimulus, result back-pressure and the verdict. Depends on dla_pkg,
// the block and lockin_checker.
`timescale 1ns / 1ps

module tb_digital_lockin_amplifier import dla_pkg::*;;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [23:0] in_sample;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_in_phase;
  logic [31:0] out_quadrature;
  logic [30:0] out_magnitude;
  logic [15:0] out_phase;
  logic [30:0] out_reference_cos;
  logic [30:0] out_second_harmonic_cos;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [39:0] cfg_wdata;
  int          pending;
  int          mismatches;

  // long receiver hold-off request, served by the stall process
  logic        hold_req;

  digital_lockin_amplifier dut (.*);

  lockin_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Global watchdog: far above the slowest legal run (the processing of every
  // sample plus the longest stalls and gaps).
  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Result back-pressure: random stall bursts, calm stretches with no stall
  // at all, and one long hold-off so the input queue fills and stalls.
  int  stall_run, calm_run, hold_left;
  bit  hold_served;

  always @(posedge clk) begin
    int k;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_run = 0; calm_run = 0; hold_left = 0; hold_served = 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req && !hold_served) begin
      hold_served = 1;
      hold_left = 3000;
      out_stall <= 1'b1;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else if (calm_run > 0) begin
      out_stall <= 1'b0;
      calm_run--;
    end else begin
      k = $urandom_range(0, 99);
      out_stall <= 1'b0;
      if (k < 50) calm_run = $urandom_range(0, 20);
      else if (k < 85) stall_run = $urandom_range(1, 10);
      else if (k < 95) stall_run = $urandom_range(50, 800);
      else calm_run = $urandom_range(2000, 5000);
    end
  end

  function automatic int sender_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // Offer one sample and hold it until the transaction completes; drop valid
  // only when a gap follows.
  task automatic send_sample(logic [23:0] value);
    int gap;
    in_valid <= 1'b1;
    in_sample <= value;
    do @(posedge clk); while (!(in_valid && !in_stall));
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [23:0] random_sample();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
    if (k < 3) return 24'($signed($urandom_range(0, 510)) - 255);
    return 24'($urandom());
  endfunction

  // Registers are written only with nothing in flight
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [39:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Q1.30 value in the low 31 bits; junk above the field is ignored
  function automatic logic [39:0] q30_word(int v);
    logic [39:0] w;
    w[30:0] = v[30:0];
    w[39:31] = 9'($urandom());
    return w;
  endfunction

  function automatic int unit_q30(real x);
    return $rtoi(x * 1073741823.0);
  endfunction

  // Pick a rotation pair: on the unit circle, at the corners, or raw noise
  task automatic pick_pair(int sel, output int c, output int s);
    real th;
    th = $urandom() / 4294967296.0 * 6.283185307179586;
    case (sel)
      0: begin c = unit_q30($cos(th)); s = unit_q30($sin(th)); end
      1: begin c = -1073741824; s = 1073741823; end
      2: begin c = 1073741823; s = -1073741824; end
      default: begin
        c = $signed({$urandom()} << 1) >>> 1;
        s = $signed({$urandom()} << 1) >>> 1;
      end
    endcase
  endtask

  task automatic program_phase(int p);
    int sc, ss, fc, fs;
    logic [39:0] k1;
    logic [16:0] g;
    pick_pair(p < 6 ? 0 : (p % 4), sc, ss);
    pick_pair(p % 5 == 4 ? 3 : (p % 3 == 1 ? 1 : 0), fc, fs);
    if (p == 1) begin g = 17'd0; k1 = 40'd0; end
    else if (p == 2) begin g = 17'h1FFFF; k1 = 40'hFF_FFFF_FFFF; end
    else begin
      g = $urandom_range(0, 3) == 0 ? 17'($urandom_range(1, 16)) : 17'($urandom());
      case ($urandom_range(0, 3))
        0: k1 = {$urandom(), 8'($urandom())};
        1: k1 = 40'd1 << 39;
        default: k1 = 40'd1 << $urandom_range(28, 38);
      endcase
    end
    write_reg(CFG_STEP_COS, q30_word(sc));
    write_reg(CFG_STEP_SIN, q30_word(ss));
    write_reg(CFG_HARMONIC, {$urandom(), 8'($urandom())} & ~40'd7 | 40'($urandom_range(0, 7)));
    write_reg(CFG_GAIN, {23'($urandom()), g});
    write_reg(CFG_COEF, k1);
    write_reg(CFG_TWO_POLE, {39'($urandom()), 1'(p % 2)});
    write_reg(CFG_FRAME_COS, q30_word(fc));
    write_reg(CFG_FRAME_SIN, q30_word(fs));
    end_writes();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_STEP_COS;
    cfg_wdata = '0;
    hold_req = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults: zero sample first (zero vector), then the sample extremes, -1, +1 and 0x555555
    send_sample(24'h000000);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'hFFFFFF);
    send_sample(24'h000001);
    send_sample(24'h555555);

    // Every harmonic, including the out-of-range selections that clamp
    for (int h = 0; h < 8; h++) begin
      wait_idle();
      if (h == 0) begin
        write_reg(CFG_STEP_COS, q30_word(unit_q30(0.9)));
        write_reg(CFG_STEP_SIN, q30_word(unit_q30(0.4358898943540674)));
        write_reg(CFG_GAIN, 40'd131071);
      end
      write_reg(CFG_HARMONIC, 40'(h));
      end_writes();
      send_sample(24'h7FFFFF);
      send_sample(24'hAAAAAA);
    end

    // Frame turned by pi (I and Q negated) with a still oscillator
    wait_idle();
    write_reg(CFG_STEP_COS, q30_word(1073741823));
    write_reg(CFG_STEP_SIN, q30_word(0));
    write_reg(CFG_HARMONIC, 40'd0);
    write_reg(CFG_COEF, 40'hFF_FFFF_FFFF);
    write_reg(CFG_TWO_POLE, 40'd0);
    write_reg(CFG_FRAME_COS, q30_word(-1073741824));
    write_reg(CFG_FRAME_SIN, q30_word(0));
    end_writes();
    send_sample(24'h7FFFFF);
    send_sample(24'h123456);

    // Random phases, each with fresh settings; one of them fills the block
    for (int p = 0; p < 12; p++) begin
      wait_idle();
      program_phase(p);
      if (p == 3) hold_req <= 1'b1;
      repeat (135) send_sample(random_sample());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
